// ----- hw/rtl/fmw_pkg.sv -----
// Shared types, constants and lookup tables for the event to FM register write translator.
package fmw_pkg;

  // Default configuration
  localparam int DEF_NUM_VOICES  = 9;
  localparam int DEF_NUM_MELODIC = 6;
  localparam int DEF_NUM_PATCHES = 18;

  // Event operation codes
  localparam logic [2:0] OP_NOTE_ON  = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF = 3'd1;
  localparam logic [2:0] OP_PROGRAM  = 3'd2;
  localparam logic [2:0] OP_DRUM     = 3'd3;
  localparam logic [2:0] OP_SILENCE  = 3'd4;

  // Chip register bases and bits
  localparam logic [7:0] REG_FNUM_LO  = 8'hA0;
  localparam logic [7:0] REG_KEY_BLK  = 8'hB0;
  localparam logic [7:0] REG_FB_CONN  = 8'hC0;
  localparam logic [7:0] REG_RHYTHM   = 8'hBD;
  localparam logic [7:0] KEY_ON_BIT   = 8'h20;
  localparam logic [7:0] RHYTHM_EN    = 8'h20;
  localparam logic [7:0] CARRIER_STEP = 8'h03;

  // Patch writes per program change: five per operator plus the channel byte
  localparam int PATCH_BYTES = 11;
  localparam int BANK_ROWS   = 18;
  localparam int HW_VOICES   = 9;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  // One voice entry in the state memory
  typedef struct packed {
    logic [2:0] block;
    logic [9:0] fnum;
    logic [4:0] patch;
  } voice_entry_t;

  localparam logic [9:0] SEMI_FNUM [12] = '{
    10'h157, 10'h16B, 10'h181, 10'h198, 10'h1B0, 10'h1CA,
    10'h1E5, 10'h202, 10'h220, 10'h241, 10'h263, 10'h287
  };

  localparam logic [4:0] OP_OFFSET [HW_VOICES] = '{
    5'h00, 5'h01, 5'h02, 5'h08, 5'h09, 5'h0A, 5'h10, 5'h11, 5'h12
  };

  // Operator register bases, in write order
  localparam logic [7:0] OPR_BASE [5] = '{8'h20, 8'h40, 8'h60, 8'h80, 8'hE0};

  localparam logic [7:0] BANK [BANK_ROWS][PATCH_BYTES] = '{
    '{8'h01,8'h4B,8'hF1,8'h53,8'h00, 8'h01,8'h00,8'hF2,8'h63,8'h00, 8'h08},
    '{8'h07,8'h12,8'hF6,8'hF2,8'h01, 8'h02,8'h00,8'hF5,8'hF3,8'h01, 8'h06},
    '{8'h21,8'h1A,8'hF0,8'h33,8'h00, 8'h21,8'h07,8'hF0,8'h33,8'h00, 8'h0A},
    '{8'h01,8'h11,8'hF5,8'h74,8'h00, 8'h01,8'h00,8'hF6,8'h74,8'h00, 8'h08},
    '{8'h01,8'h0C,8'hF1,8'h52,8'h00, 8'h01,8'h00,8'hF4,8'h72,8'h00, 8'h08},
    '{8'h21,8'h1E,8'h62,8'h14,8'h00, 8'h21,8'h00,8'h53,8'h14,8'h00, 8'h0A},
    '{8'hA1,8'h1E,8'h51,8'h14,8'h00, 8'h21,8'h00,8'h41,8'h14,8'h00, 8'h0A},
    '{8'h21,8'h0C,8'h71,8'h21,8'h00, 8'h21,8'h00,8'h61,8'h21,8'h00, 8'h0C},
    '{8'h31,8'h1C,8'h51,8'h33,8'h00, 8'h21,8'h00,8'h52,8'h24,8'h00, 8'h0A},
    '{8'h21,8'h1B,8'h91,8'h17,8'h00, 8'h21,8'h00,8'h81,8'h17,8'h00, 8'h0C},
    '{8'h21,8'h10,8'hF1,8'h11,8'h00, 8'h21,8'h00,8'hF1,8'h11,8'h00, 8'h0E},
    '{8'h21,8'h1E,8'h31,8'h18,8'h00, 8'h21,8'h00,8'h21,8'h18,8'h00, 8'h0A},
    '{8'h61,8'h1D,8'h51,8'h16,8'h02, 8'h21,8'h00,8'h41,8'h16,8'h02, 8'h0A},
    '{8'h01,8'h11,8'hF6,8'h84,8'h00, 8'h01,8'h00,8'hF7,8'h94,8'h00, 8'h08},
    '{8'h07,8'h00,8'hF7,8'hF7,8'h00, 8'h01,8'h00,8'hF7,8'hF8,8'h00, 8'h06},
    '{8'h0F,8'h00,8'hF0,8'hFF,8'h03, 8'h00,8'h00,8'hF0,8'hFF,8'h03, 8'h00},
    '{8'h01,8'h26,8'hF2,8'h43,8'h01, 8'h01,8'h00,8'hF2,8'h53,8'h01, 8'h08},
    '{8'h21,8'h0C,8'hF2,8'h42,8'h00, 8'h21,8'h00,8'hF3,8'h42,8'h00, 8'h08}
  };

  // Bank byte lookup; rows past the populated bank read as zero
  function automatic logic [7:0] bank_byte(input logic [4:0] patch, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if ((patch < 5'(BANK_ROWS)) && (idx < 4'(PATCH_BYTES))) begin
      b = BANK[patch][idx];
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/fmw_ram.sv -----
// Generic single-port-write, registered-read RAM.
module fmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/midi_event_to_fm_register_writes.sv -----
// Top level: turns MIDI-like events into runs of FM chip register writes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in_     | input     | in_valid/in_ready  | operation, voice, note, program_req, drum_bits
//   out_    | output    | out_valid/out_ready| reg_addr, reg_data, last
//
// One event is handled at a time, and each is first accepted. Note on: read, F-number and
// key-on writes. Note off: read, key-off write. Program change: read, then the 11 patch
// writes only if the patch changes. Drum strike: 2 rhythm writes. Silence all: a read and
// key-off write per voice, then a rhythm write. Out-of-range or unknown events: dropped.
// Reset is synchronous; voice entries read as zero until first written (valid bits).
// A stalled output holds the run; the next event is taken while the last write waits.
module midi_event_to_fm_register_writes #(
  parameter int NUM_VOICES  = fmw_pkg::DEF_NUM_VOICES,
  parameter int NUM_MELODIC = fmw_pkg::DEF_NUM_MELODIC,
  parameter int NUM_PATCHES = fmw_pkg::DEF_NUM_PATCHES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [3:0] in_voice,
  input  logic [6:0] in_note,
  input  logic [6:0] in_program_req,
  input  logic [4:0] in_drum_bits,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_reg_addr,
  output logic [7:0] out_reg_data,
  output logic       out_last
);

  import fmw_pkg::*;

  localparam int AW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int VOICE_LIMIT = (NUM_MELODIC < NUM_VOICES) ? NUM_MELODIC : NUM_VOICES;
  localparam int EW = $bits(voice_entry_t);

  state_t       state_r, state_nxt;
  logic [2:0]   op_r;
  logic [3:0]   tgt_r, tgt_nxt;
  logic [6:0]   note_r;
  logic [6:0]   prog_r;
  logic [4:0]   drums_r;
  logic [3:0]   idx_r, idx_nxt;
  voice_entry_t cur_r;
  logic         rd_valid_r;
  logic [NUM_VOICES-1:0] valid_r;

  logic         out_valid_r;
  logic [7:0]   out_addr_r;
  logic [7:0]   out_data_r;
  logic         out_last_r;

  logic         accept, load;
  logic         acc_voice_ok, acc_read;
  logic         rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] ram_rdata;
  voice_entry_t rd_entry, wr_entry;
  logic         patch_same;

  logic [12:0]  q_full;
  logic [3:0]   octave_q, octave_m1;
  logic [6:0]   rem_full;
  logic [2:0]   oct;
  logic [9:0]   fnum;
  logic [4:0]   patch_map, patch_sel;
  logic [4:0]   scan_inc;
  logic         scan_more;

  logic [7:0]   em_addr, em_data;
  logic         em_last, em_scan_more;
  logic [4:0]   m_off;
  logic [2:0]   fld;

  // Handshake decode
  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign load         = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign acc_voice_ok = ({1'b0, in_voice} < 5'(VOICE_LIMIT));
  assign acc_read     = ((in_operation == OP_NOTE_ON) || (in_operation == OP_NOTE_OFF) ||
                         (in_operation == OP_PROGRAM)) ? acc_voice_ok
                                                      : (in_operation == OP_SILENCE);

  // Note split: note/12 via reciprocal (exact for 7-bit notes), then clamp octave-1
  assign q_full    = 13'(note_r) * 13'd43;
  assign octave_q  = q_full[12:9];
  assign octave_m1 = octave_q - 4'd1;
  assign rem_full  = note_r - (7'(octave_q) * 7'd12);
  assign oct       = (octave_q == 4'd0) ? 3'd0 :
                     ((octave_m1 > 4'd7) ? 3'd7 : octave_m1[2:0]);
  assign fnum      = SEMI_FNUM[rem_full[3:0]];

  // Program to patch mapping with saturation at the bank size
  always_comb begin
    if ((prog_r == 7'd4) || (prog_r == 7'd5)) begin
      patch_map = 5'd16;
    end else if ((prog_r == 7'd38) || (prog_r == 7'd39)) begin
      patch_map = 5'd17;
    end else begin
      patch_map = {1'b0, prog_r[6:3]};
    end
    if ({1'b0, patch_map} >= 6'(NUM_PATCHES)) begin
      patch_sel = 5'(NUM_PATCHES - 1);
    end else begin
      patch_sel = patch_map;
    end
  end

  // Voice state memory: entries never written read as zero
  assign rd_entry   = rd_valid_r ? voice_entry_t'(ram_rdata) : '0;
  assign patch_same = (patch_sel == rd_entry.patch);
  assign scan_inc   = {1'b0, tgt_r} + 5'd1;
  assign scan_more  = (scan_inc < 5'(VOICE_LIMIT));

  always_comb begin
    wr_entry = rd_entry;
    if (op_r == OP_NOTE_ON) begin
      wr_entry.block = oct;
      wr_entry.fnum  = fnum;
    end else begin
      wr_entry.patch = patch_sel;
    end
  end

  // Memory port control
  always_comb begin
    rd_en   = (accept && acc_read) || (load && em_scan_more);
    rd_addr = scan_inc[AW-1:0];
    if (accept) begin
      rd_addr = (in_operation == OP_SILENCE) ? '0 : in_voice[AW-1:0];
    end
    wr_en   = (state_r == S_READ) &&
              ((op_r == OP_NOTE_ON) || ((op_r == OP_PROGRAM) && !patch_same));
    wr_addr = tgt_r[AW-1:0];
  end

  fmw_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_VOICES),
    .AW    (AW)
  ) u_voice_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (EW'(wr_entry)),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Write generator for the current step of the run
  assign m_off = OP_OFFSET[tgt_r];
  assign fld   = (idx_r < 4'd5) ? idx_r[2:0] : 3'(idx_r - 4'd5);

  always_comb begin
    em_addr      = 8'h00;
    em_data      = 8'h00;
    em_last      = 1'b1;
    em_scan_more = 1'b0;
    case (op_r)
      OP_NOTE_ON: begin
        if (idx_r == 4'd0) begin
          em_addr = REG_FNUM_LO + 8'(tgt_r);
          em_data = fnum[7:0];
          em_last = 1'b0;
        end else begin
          em_addr = REG_KEY_BLK + 8'(tgt_r);
          em_data = KEY_ON_BIT | {3'b000, oct, fnum[9:8]};
        end
      end
      OP_NOTE_OFF: begin
        em_addr = REG_KEY_BLK + 8'(tgt_r);
        em_data = {3'b000, cur_r.block, cur_r.fnum[9:8]};
      end
      OP_PROGRAM: begin
        if (idx_r < 4'd10) begin
          em_addr = OPR_BASE[fld] + 8'(m_off) + ((idx_r >= 4'd5) ? CARRIER_STEP : 8'h00);
          em_last = 1'b0;
        end else begin
          em_addr = REG_FB_CONN + 8'(tgt_r);
        end
        em_data = bank_byte(patch_sel, idx_r);
      end
      OP_DRUM: begin
        em_addr = REG_RHYTHM;
        if (idx_r == 4'd0) begin
          em_data = RHYTHM_EN;
          em_last = 1'b0;
        end else begin
          em_data = RHYTHM_EN | {3'b000, drums_r};
        end
      end
      OP_SILENCE: begin
        if (idx_r == 4'd0) begin
          em_addr      = REG_KEY_BLK + 8'(tgt_r);
          em_data      = {3'b000, cur_r.block, cur_r.fnum[9:8]};
          em_last      = 1'b0;
          em_scan_more = scan_more;
        end else begin
          em_addr = REG_RHYTHM;
          em_data = RHYTHM_EN;
        end
      end
      default: begin
        em_last = 1'b1;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (acc_read) begin
            state_nxt = S_READ;
          end else if (in_operation == OP_DRUM) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_READ: begin
        if ((op_r == OP_PROGRAM) && patch_same) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          if (em_last) begin
            state_nxt = S_IDLE;
          end else if (em_scan_more) begin
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Step and voice counters
  always_comb begin
    idx_nxt = idx_r;
    tgt_nxt = tgt_r;
    if (accept) begin
      idx_nxt = 4'd0;
      tgt_nxt = (in_operation == OP_SILENCE) ? 4'd0 : in_voice;
    end else if (load && !em_last) begin
      if (em_scan_more) begin
        tgt_nxt = scan_inc[3:0];
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      tgt_r       <= 4'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      tgt_r   <= tgt_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      note_r  <= in_note;
      prog_r  <= in_program_req;
      drums_r <= in_drum_bits;
    end
    if (rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
    end
    if (state_r == S_READ) begin
      cur_r <= rd_entry;
    end
    if (load) begin
      out_addr_r <= em_addr;
      out_data_r <= em_data;
      out_last_r <= em_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_reg_addr = out_addr_r;
  assign out_reg_data = out_data_r;
  assign out_last     = out_last_r;

endmodule

// ----- hw/rtl/fmw_checker.sv -----
// Port-level checks for the translator, bound onto the top level.
module fmw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_operation,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_reg_addr,
  input logic [7:0] out_reg_data,
  input logic       out_last
);

  import fmw_pkg::*;

  // Stalled write holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reg_addr) &&
    $stable(out_reg_data) && $stable(out_last))
    else $error("stalled output write changed");

  // A drum strike always starts a run, so input is closed the next cycle
  a_drum_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_DRUM) |=> !in_ready)
    else $error("drum strike did not start a run");

  // Unknown codes are dropped at once
  a_unknown_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation > OP_SILENCE)
    |=> in_ready)
    else $error("unknown operation occupied the block");

  // A rhythm write that does not close its run is the drum preamble
  a_rhythm_pre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reg_addr == REG_RHYTHM) && !out_last |-> out_reg_data == RHYTHM_EN)
    else $error("rhythm preamble carries wrong data");

endmodule

bind midi_event_to_fm_register_writes fmw_checker u_fmw_checker (.*);

// ----- verif/midi_event_to_fm_register_writes_tb.sv -----
// Self-checking testbench for the MIDI event to FM register write translator.
`timescale 1ns / 100ps

module midi_event_to_fm_register_writes_tb;
  import fmw_pkg::*;

  localparam int MELODIC      = fmw_pkg::DEF_NUM_MELODIC;
  localparam int PATCHES      = fmw_pkg::DEF_NUM_PATCHES;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  // Operation codes the block does not define
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Semitone to F-number
  localparam logic [9:0] FNUM_TABLE [12] = '{
    10'h157, 10'h16B, 10'h181, 10'h198, 10'h1B0, 10'h1CA,
    10'h1E5, 10'h202, 10'h220, 10'h241, 10'h263, 10'h287
  };

  // Modulator slot offset per voice; the carrier sits three slots above
  localparam logic [7:0] MOD_SLOT [9] = '{
    8'h00, 8'h01, 8'h02, 8'h08, 8'h09, 8'h0A, 8'h10, 8'h11, 8'h12
  };

  // Operator register groups, in the order a patch load writes them
  localparam logic [7:0] OPER_GROUP [5] = '{8'h20, 8'h40, 8'h60, 8'h80, 8'hE0};

  // Patch bank: five modulator bytes, five carrier bytes, feedback/connection
  localparam logic [7:0] PATCH_BANK [18][11] = '{
    '{8'h01,8'h4B,8'hF1,8'h53,8'h00, 8'h01,8'h00,8'hF2,8'h63,8'h00, 8'h08},
    '{8'h07,8'h12,8'hF6,8'hF2,8'h01, 8'h02,8'h00,8'hF5,8'hF3,8'h01, 8'h06},
    '{8'h21,8'h1A,8'hF0,8'h33,8'h00, 8'h21,8'h07,8'hF0,8'h33,8'h00, 8'h0A},
    '{8'h01,8'h11,8'hF5,8'h74,8'h00, 8'h01,8'h00,8'hF6,8'h74,8'h00, 8'h08},
    '{8'h01,8'h0C,8'hF1,8'h52,8'h00, 8'h01,8'h00,8'hF4,8'h72,8'h00, 8'h08},
    '{8'h21,8'h1E,8'h62,8'h14,8'h00, 8'h21,8'h00,8'h53,8'h14,8'h00, 8'h0A},
    '{8'hA1,8'h1E,8'h51,8'h14,8'h00, 8'h21,8'h00,8'h41,8'h14,8'h00, 8'h0A},
    '{8'h21,8'h0C,8'h71,8'h21,8'h00, 8'h21,8'h00,8'h61,8'h21,8'h00, 8'h0C},
    '{8'h31,8'h1C,8'h51,8'h33,8'h00, 8'h21,8'h00,8'h52,8'h24,8'h00, 8'h0A},
    '{8'h21,8'h1B,8'h91,8'h17,8'h00, 8'h21,8'h00,8'h81,8'h17,8'h00, 8'h0C},
    '{8'h21,8'h10,8'hF1,8'h11,8'h00, 8'h21,8'h00,8'hF1,8'h11,8'h00, 8'h0E},
    '{8'h21,8'h1E,8'h31,8'h18,8'h00, 8'h21,8'h00,8'h21,8'h18,8'h00, 8'h0A},
    '{8'h61,8'h1D,8'h51,8'h16,8'h02, 8'h21,8'h00,8'h41,8'h16,8'h02, 8'h0A},
    '{8'h01,8'h11,8'hF6,8'h84,8'h00, 8'h01,8'h00,8'hF7,8'h94,8'h00, 8'h08},
    '{8'h07,8'h00,8'hF7,8'hF7,8'h00, 8'h01,8'h00,8'hF7,8'hF8,8'h00, 8'h06},
    '{8'h0F,8'h00,8'hF0,8'hFF,8'h03, 8'h00,8'h00,8'hF0,8'hFF,8'h03, 8'h00},
    '{8'h01,8'h26,8'hF2,8'h43,8'h01, 8'h01,8'h00,8'hF2,8'h53,8'h01, 8'h08},
    '{8'h21,8'h0C,8'hF2,8'h42,8'h00, 8'h21,8'h00,8'hF3,8'h42,8'h00, 8'h08}
  };

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } fm_write_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_operation = '0;
  logic [3:0] in_voice = '0;
  logic [6:0] in_note = '0;
  logic [6:0] in_program_req = '0;
  logic [4:0] in_drum_bits = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_reg_addr;
  logic [7:0] out_reg_data;
  logic       out_last;

  // Shadow of the per-voice state
  logic [2:0] shadow_block [9];
  logic [9:0] shadow_fnum  [9];
  logic [4:0] shadow_patch [9];

  fm_write_t  pending_writes [$];
  fm_write_t  head_write;
  int         errors = 0;
  int         writes_checked = 0;
  int         event_count [8];
  int         spare_events = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_request = 0;
  int         hold_left = 0;
  int         cycle_count = 0;

  midi_event_to_fm_register_writes u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_voice       (in_voice),
    .in_note        (in_note),
    .in_program_req (in_program_req),
    .in_drum_bits   (in_drum_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reg_addr   (out_reg_addr),
    .out_reg_data   (out_reg_data),
    .out_last       (out_last)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
    $display("midi_event_to_fm_register_writes test failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold when a test asks for one
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each write transfer against the oldest expected write
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write addr=%02h data=%02h last=%0b", $time,
                 out_reg_addr, out_reg_data, out_last);
        errors++;
      end else begin
        head_write = pending_writes.pop_front();
        writes_checked++;
        if (out_reg_addr !== head_write.addr) begin
          $display("%0t: reg_addr expected %02h actual %02h", $time,
                   head_write.addr, out_reg_addr);
          errors++;
        end
        if (out_reg_data !== head_write.data) begin
          $display("%0t: reg_data expected %02h actual %02h (addr %02h)", $time,
                   head_write.data, out_reg_data, head_write.addr);
          errors++;
        end
        if (out_last !== head_write.last) begin
          $display("%0t: last expected %0b actual %0b (addr %02h)", $time,
                   head_write.last, out_last, head_write.addr);
          errors++;
        end
      end
    end
  end

  function automatic fm_write_t fm_wr(input logic [7:0] addr, input logic [7:0] data);
    fm_write_t w;
    w.addr = addr;
    w.data = data;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic fm_write_t key_off_write(input int v);
    return fm_wr(8'hB0 + 8'(v), 8'({shadow_block[v], shadow_fnum[v][9:8]}));
  endfunction

  // Expected register writes for one accepted event; updates the shadow state
  task automatic predict_fm_writes(input logic [2:0] op, input logic [3:0] voice,
                                   input logic [6:0] note, input logic [6:0] prog,
                                   input logic [4:0] drums);
    fm_write_t  run [$];
    logic [9:0] fnum;
    logic [4:0] patch;
    logic [7:0] mod;
    int         octave;
    bit         in_range;
    in_range = (int'(voice) < MELODIC);
    case (op)
      OP_NOTE_ON: begin
        if (in_range) begin
          octave = int'(note) / 12;
          octave = (octave == 0) ? 0 : octave - 1;
          if (octave > 7) octave = 7;
          fnum = FNUM_TABLE[int'(note) % 12];
          shadow_block[voice] = 3'(octave);
          shadow_fnum[voice] = fnum;
          run.push_back(fm_wr(8'hA0 + 8'(voice), fnum[7:0]));
          run.push_back(fm_wr(8'hB0 + 8'(voice),
                              8'h20 | 8'({3'(octave), fnum[9:8]})));
        end
      end
      OP_NOTE_OFF: begin
        if (in_range) run.push_back(key_off_write(int'(voice)));
      end
      OP_PROGRAM: begin
        if (in_range) begin
          // GM program to bank patch, with the two remapped pairs
          if (prog == 7'd4 || prog == 7'd5) patch = 5'd16;
          else if (prog == 7'd38 || prog == 7'd39) patch = 5'd17;
          else patch = 5'(prog >> 3);
          if (int'(patch) >= PATCHES) patch = 5'(PATCHES - 1);
          if (patch != shadow_patch[voice]) begin
            mod = MOD_SLOT[voice];
            for (int i = 0; i < 5; i++)
              run.push_back(fm_wr(OPER_GROUP[i] + mod, PATCH_BANK[patch][i]));
            for (int i = 0; i < 5; i++)
              run.push_back(fm_wr(OPER_GROUP[i] + mod + 8'h03, PATCH_BANK[patch][i + 5]));
            run.push_back(fm_wr(8'hC0 + 8'(voice), PATCH_BANK[patch][10]));
            shadow_patch[voice] = patch;
          end
        end
      end
      OP_DRUM: begin
        run.push_back(fm_wr(8'hBD, 8'h20));
        run.push_back(fm_wr(8'hBD, 8'h20 | 8'(drums)));
      end
      OP_SILENCE: begin
        for (int i = 0; i < MELODIC; i++) run.push_back(key_off_write(i));
        run.push_back(fm_wr(8'hBD, 8'h20));
      end
      default: begin
      end
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_writes.push_back(run[i]);
  endtask

  // Offer one event, wait for its transfer, then predict its writes
  task automatic send_event(input logic [2:0] op, input logic [3:0] voice,
                            input logic [6:0] note, input logic [6:0] prog,
                            input logic [4:0] drums);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_voice       <= voice;
    in_note        <= note;
    in_program_req <= prog;
    in_drum_bits   <= drums;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    event_count[op]++;
    predict_fm_writes(op, voice, note, prog, drums);
  endtask

  // Note range ends, block clamp and note off from stored and reset state
  task automatic test_note_on_off();
    send_event(OP_NOTE_ON, 4'd0, 7'd0, 7'($urandom), 5'($urandom));
    send_event(OP_NOTE_ON, 4'd5, 7'd127, 7'($urandom), 5'($urandom));
    send_event(OP_NOTE_ON, 4'd0, 7'd11, 7'($urandom), 5'($urandom));
    send_event(OP_NOTE_ON, 4'd3, 7'd12, 7'($urandom), 5'($urandom));
    send_event(OP_NOTE_ON, 4'd1, 7'd60, 7'($urandom), 5'($urandom));
    send_event(OP_NOTE_OFF, 4'd0, 7'($urandom), 7'($urandom), 5'($urandom));
    send_event(OP_NOTE_OFF, 4'd5, 7'($urandom), 7'($urandom), 5'($urandom));
    send_event(OP_NOTE_OFF, 4'd2, 7'($urandom), 7'($urandom), 5'($urandom));
  endtask

  // Program mapping: unchanged patch, remapped pairs, top program, plain rows
  task automatic test_program_change();
    send_event(OP_PROGRAM, 4'd0, 7'($urandom), 7'd0, 5'($urandom));
    send_event(OP_PROGRAM, 4'd0, 7'($urandom), 7'd4, 5'($urandom));
    send_event(OP_PROGRAM, 4'd1, 7'($urandom), 7'd38, 5'($urandom));
    send_event(OP_PROGRAM, 4'd2, 7'($urandom), 7'd127, 5'($urandom));
    send_event(OP_PROGRAM, 4'd3, 7'($urandom), 7'd39, 5'($urandom));
    send_event(OP_PROGRAM, 4'd4, 7'($urandom), 7'd5, 5'($urandom));
    send_event(OP_PROGRAM, 4'd0, 7'($urandom), 7'd8, 5'($urandom));
  endtask

  task automatic test_drum_and_silence();
    send_event(OP_DRUM, 4'($urandom), 7'($urandom), 7'($urandom), 5'd0);
    send_event(OP_DRUM, 4'($urandom), 7'($urandom), 7'($urandom), 5'd31);
    send_event(OP_SILENCE, 4'($urandom), 7'($urandom), 7'($urandom), 5'($urandom));
  endtask

  // Events that must produce nothing, and drum strike on a high voice number
  task automatic test_ignored_events();
    send_event(OP_NOTE_ON, 4'd6, 7'd64, 7'($urandom), 5'($urandom));
    send_event(OP_NOTE_OFF, 4'd15, 7'($urandom), 7'($urandom), 5'($urandom));
    send_event(OP_PROGRAM, 4'd9, 7'($urandom), 7'd100, 5'($urandom));
    send_event(OP_SPARE_LO, 4'd0, 7'd60, 7'd40, 5'd31);
    send_event(OP_SPARE_HI, 4'd5, 7'd127, 7'd127, 5'd31);
    send_event(OP_DRUM, 4'd15, 7'($urandom), 7'($urandom), 5'($urandom));
  endtask

  // Mostly in-range voices with random content; some noise events
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    int         sel;
    logic [2:0] op;
    logic [3:0] voice;
    logic [6:0] prog;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 28) op = OP_NOTE_ON;
      else if (sel < 44) op = OP_NOTE_OFF;
      else if (sel < 66) op = OP_PROGRAM;
      else if (sel < 78) op = OP_DRUM;
      else if (sel < 86) op = OP_SILENCE;
      else op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      voice = ($urandom_range(99) < 85) ? 4'($urandom_range(MELODIC - 1))
                                        : 4'($urandom_range(15, MELODIC));
      case ($urandom_range(9))
        0: prog = 7'd4;
        1: prog = 7'd39;
        default: prog = 7'($urandom);
      endcase
      send_event(op, voice, 7'($urandom), prog, 5'($urandom));
    end
  endtask

  // Long receiver hold while long runs keep coming, so the input stalls
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 12; n++) begin
      case (n % 3)
        0: send_event(OP_SILENCE, 4'($urandom), 7'($urandom), 7'($urandom), 5'($urandom));
        1: send_event(OP_PROGRAM, 4'($urandom_range(MELODIC - 1)), 7'($urandom),
                      (n % 2 == 0) ? 7'd0 : 7'd127, 5'($urandom));
        default: send_event(OP_DRUM, 4'($urandom), 7'($urandom), 7'($urandom),
                            5'($urandom));
      endcase
    end
  endtask

  // Test sequence
  initial begin
    for (int i = 0; i < 9; i++) begin
      shadow_block[i] = '0;
      shadow_fnum[i]  = '0;
      shadow_patch[i] = '0;
    end
    foreach (event_count[i]) event_count[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 52;
    test_note_on_off();
    test_program_change();
    test_drum_and_silence();
    test_ignored_events();
    test_random_traffic(45, 14, 52);
    test_random_traffic(45, 52, 14);
    test_random_traffic(40, 0, 0);
    test_output_hold();
    in_valid <= 1'b0;

    // Drain, then allow for any stray writes
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (int i = int'(OP_SPARE_LO); i <= int'(OP_SPARE_HI); i++)
      spare_events += event_count[i];
    $display("Covered %0d note on, %0d note off, %0d program, %0d drum, %0d silence, %0d spare",
             event_count[OP_NOTE_ON], event_count[OP_NOTE_OFF], event_count[OP_PROGRAM],
             event_count[OP_DRUM], event_count[OP_SILENCE], spare_events);
    $display("%0d register writes checked over three stall mixes and a long output hold",
             writes_checked);
    if (errors == 0) begin
      $display("midi_event_to_fm_register_writes test passed");
    end else begin
      $display("midi_event_to_fm_register_writes test failed");
    end
    $finish;
  end

endmodule

// ----- midi_event_to_fm_register_writes.f -----
hw/rtl/fmw_pkg.sv
hw/rtl/fmw_ram.sv
hw/rtl/midi_event_to_fm_register_writes.sv
hw/rtl/fmw_checker.sv
verif/midi_event_to_fm_register_writes_tb.sv
